// ----- rtl/prq_pkg.sv -----
// ----------------------------------------------------------------------------
// prq_pkg: shared types and constants for the packet reorder priority queue
// Entry layout, status codes and the controller/datapath command interface.
// ----------------------------------------------------------------------------
package prq_pkg;

    // Storage depth; the circular buffer wraps by index overflow, so keep it
    // a power of two
    localparam int DEPTH  = 64;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int LIM_W  = 7;
    localparam int HELD_W = 7;
    localparam int CMP_W  = CNT_W + LIM_W;

    localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(64);

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    // One stored entry: sort key plus handle
    typedef struct packed {
        logic [31:0] epoch;
        logic [63:0] pts;
        logic [63:0] dts;
        logic [31:0] seq;
        logic [15:0] handle;
    } entry_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic    capture;    // latch the accepted beat, clear the result
        logic    mem_rd;     // issue a memory read
        logic    rd_head;    // read at head instead of the slot below pos
        logic    mem_wr;     // write the memory at head + pos
        logic    wr_new;     // write the new entry instead of the read data
        logic    pos_dec;    // step the insertion point down
        logic    cnt_inc;    // one more stored entry
        logic    pop_take;   // take read data as result, advance head
        logic    set_status; // record a status code
        status_t status;
        logic    load_out;   // move result into the output register
    } prq_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic is_pop;
        logic empty;
        logic full;
        logic pos_zero;
        logic key_below;
    } prq_stat_t;

endpackage

// ----- rtl/prq_dp.sv -----
// ----------------------------------------------------------------------------
// prq_dp: datapath of the packet reorder priority queue
// Circular entry memory, head/count/insertion pointers, key compare and the
// result and output registers.
// ----------------------------------------------------------------------------
module prq_dp
    import prq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  prq_cmd_t                cmd,
    output prq_stat_t               stat,
    input  logic                    cfg_wr_en,
    input  logic [LIM_W-1:0]        cfg_wr_data,
    input  logic                    operation,
    input  logic [31:0]             entry_epoch,
    input  logic signed [63:0]      entry_pts,
    input  logic signed [63:0]      entry_dts,
    input  logic [31:0]             entry_seq,
    input  logic [15:0]             entry_handle,
    output logic [1:0]              status,
    output logic [31:0]             out_epoch,
    output logic signed [63:0]      out_pts,
    output logic signed [63:0]      out_dts,
    output logic [31:0]             out_seq,
    output logic [15:0]             out_handle,
    output logic [HELD_W-1:0]       entries_held
);

    localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;

    entry_t             mem [DEPTH];
    entry_t             rd_reg;
    entry_t             new_reg;
    logic               op_reg;
    logic [LIM_W-1:0]   limit_reg;
    logic [IDX_W-1:0]   head_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   pos_reg;
    status_t            res_status_reg;
    entry_t             res_entry_reg;
    status_t            out_status_reg;
    entry_t             out_entry_reg;
    logic [CNT_W-1:0]   out_count_reg;

    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic [CMP_W-1:0]   lim_ext;
    logic [CMP_W-1:0]   lim_eff;
    logic [191:0]       key_new;
    logic [191:0]       key_old;

    // Address the slot below the insertion point, or the head for a pop
    assign rd_addr = cmd.rd_head ? head_reg
                                 : head_reg + IDX_W'(pos_reg - CNT_W'(1));
    assign wr_addr = head_reg + pos_reg[IDX_W-1:0];

    // Saturate the limit at the storage depth
    assign lim_ext = CMP_W'(limit_reg);
    assign lim_eff = (lim_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : lim_ext;

    // Compare keys with the timestamps offset to unsigned order
    assign key_new = {new_reg.epoch, new_reg.pts ^ SIGN64,
                      new_reg.dts ^ SIGN64, new_reg.seq};
    assign key_old = {rd_reg.epoch, rd_reg.pts ^ SIGN64,
                      rd_reg.dts ^ SIGN64, rd_reg.seq};

    assign stat.is_pop    = op_reg;
    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (CMP_W'(count_reg) >= lim_eff);
    assign stat.pos_zero  = (pos_reg == '0);
    assign stat.key_below = (key_new < key_old);

    // Entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            mem[wr_addr] <= cmd.wr_new ? new_reg : rd_reg;
        end
        if (cmd.mem_rd)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    // Hold the accepted beat
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg         <= operation;
            new_reg.epoch  <= entry_epoch;
            new_reg.pts    <= entry_pts;
            new_reg.dts    <= entry_dts;
            new_reg.seq    <= entry_seq;
            new_reg.handle <= entry_handle;
        end
    end

    // Queue pointers and limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
            head_reg  <= '0;
            count_reg <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            if (cmd.capture)
            begin
                pos_reg <= count_reg;
            end
            else if (cmd.pos_dec)
            begin
                pos_reg <= pos_reg - CNT_W'(1);
            end
            if (cmd.cnt_inc)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.pop_take)
            begin
                count_reg <= count_reg - CNT_W'(1);
                head_reg  <= head_reg + IDX_W'(1);
            end
        end
    end

    // Result staging and output register
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            res_entry_reg <= '0;
        end
        else if (cmd.pop_take)
        begin
            res_entry_reg <= rd_reg;
        end
        if (cmd.set_status)
        begin
            res_status_reg <= cmd.status;
        end
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_entry_reg  <= res_entry_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign status       = out_status_reg;
    assign out_epoch    = out_entry_reg.epoch;
    assign out_pts      = out_entry_reg.pts;
    assign out_dts      = out_entry_reg.dts;
    assign out_seq      = out_entry_reg.seq;
    assign out_handle   = out_entry_reg.handle;
    assign entries_held = HELD_W'(out_count_reg);

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("prq_dp: count beyond depth");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_inc |-> !stat.full && !stat.is_pop)
        else $error("prq_dp: entry stored into a full queue");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_take |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("prq_dp: pop did not drop the count");

    a_insert_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_wr |-> pos_reg <= count_reg)
        else $error("prq_dp: write past the queue tail");
`endif

endmodule

// ----- rtl/prq_ctrl.sv -----
// ----------------------------------------------------------------------------
// prq_ctrl: controller of the packet reorder priority queue
// Sequences one operation at a time: decide, insertion scan or head read,
// then hand the result to the output register.
// ----------------------------------------------------------------------------
module prq_ctrl
    import prq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  prq_stat_t stat,
    output prq_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_CMP,
        ST_POP_RD,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   can_load;

    assign accept   = in_valid && in_ready_reg;
    assign can_load = !out_valid_reg || out_ready;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = STAT_OK;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture    = 1'b1;
                    cmd.set_status = 1'b1;
                    state_next     = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (stat.is_pop)
                begin
                    if (stat.empty)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = STAT_EMPTY;
                        state_next     = ST_FINISH;
                    end
                    else
                    begin
                        cmd.mem_rd  = 1'b1;
                        cmd.rd_head = 1'b1;
                        state_next  = ST_POP_RD;
                    end
                end
                else if (stat.full)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = STAT_FULL;
                    state_next     = ST_FINISH;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.pos_zero)
                begin
                    cmd.mem_wr  = 1'b1;
                    cmd.wr_new  = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    cmd.mem_rd = 1'b1;
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                // Shift the larger entry up, or drop the new one in place
                cmd.mem_wr = 1'b1;
                if (stat.key_below)
                begin
                    cmd.pos_dec = 1'b1;
                    state_next  = ST_SCAN;
                end
                else
                begin
                    cmd.wr_new  = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    state_next  = ST_FINISH;
                end
            end
            ST_POP_RD:
            begin
                cmd.pop_take = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (can_load)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output beat valid: set on load, clear when taken
    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // State and registered handshake outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= (state_next == ST_IDLE);
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

`ifndef SYNTH
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready_reg |-> state_reg == ST_IDLE)
        else $error("prq_ctrl: ready outside idle");

    a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CMP |-> $past(cmd.mem_rd))
        else $error("prq_ctrl: compare without a read");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !out_valid_reg || out_ready)
        else $error("prq_ctrl: output register overwritten");
`endif

endmodule

// ----- rtl/packet_reorder_priority_queue.sv -----
// Flow: a pop reads the head entry; a refused push or an empty pop goes straight
//   to the result; a push reads and compares each stored entry it passes, moving it
//   up one slot, and writes the new entry where the scan stops.
// Throughput: one operation at a time; the next beat is accepted from the cycle after
//   the result loads, and the load waits while out_ready holds off the last one.
// Reset: asynchronous, clears the queue to empty and the limit to 64.
// ----------------------------------------------------------------------------
// packet_reorder_priority_queue: sorted reorder queue for media packets
// Keeps entries ordered by epoch, pts, dts, sequence; push inserts after
// equal keys, pop returns the smallest entry.
// ----------------------------------------------------------------------------
module packet_reorder_priority_queue
    import prq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [LIM_W-1:0]    cfg_wr_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                operation,
    input  logic [31:0]         entry_epoch,
    input  logic signed [63:0]  entry_pts,
    input  logic signed [63:0]  entry_dts,
    input  logic [31:0]         entry_seq,
    input  logic [15:0]         entry_handle,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          status,
    output logic [31:0]         out_epoch,
    output logic signed [63:0]  out_pts,
    output logic signed [63:0]  out_dts,
    output logic [31:0]         out_seq,
    output logic [15:0]         out_handle,
    output logic [HELD_W-1:0]   entries_held
);

    prq_cmd_t  cmd;
    prq_stat_t stat;

    // Sequencer
    prq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Storage and compare
    prq_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .operation    (operation),
        .entry_epoch  (entry_epoch),
        .entry_pts    (entry_pts),
        .entry_dts    (entry_dts),
        .entry_seq    (entry_seq),
        .entry_handle (entry_handle),
        .status       (status),
        .out_epoch    (out_epoch),
        .out_pts      (out_pts),
        .out_dts      (out_dts),
        .out_seq      (out_seq),
        .out_handle   (out_handle),
        .entries_held (entries_held)
    );

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench for packet_reorder_priority_queue
// Sends push and pop beats under random idling and back-pressure. A sorted
// queue model predicts every result, and each result is checked field by field
// in arrival order. A short table covers the extremes of the keys, ties,
// refusals at the limit, empty pops and limit changes. Random phases follow,
// each with its own limit.
// ----------------------------------------------------------------------------
module tb
    import prq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int STALL_CYCLES = 400;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASES       = 5;

    localparam logic [63:0] STAMP_MIN  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] STAMP_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] STAMP_NEG1 = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_code_t;

    typedef enum logic {
        ROW_BEAT  = 1'b0,
        ROW_LIMIT = 1'b1
    } row_kind_t;

    typedef struct packed {
        status_t           status;
        entry_t            ent;
        logic [HELD_W-1:0] held;
    } result_t;

    typedef struct packed {
        row_kind_t        kind;
        op_code_t         op;
        entry_t           ent;
        logic [LIM_W-1:0] limit;
        logic             typed;
        result_t          want;
    } row_t;

    // DUT ports
    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                cfg_wr_en    = 1'b0;
    logic [LIM_W-1:0]    cfg_wr_data  = '0;
    logic                in_valid     = 1'b0;
    logic                in_ready;
    logic                operation    = 1'b0;
    logic [31:0]         entry_epoch  = '0;
    logic signed [63:0]  entry_pts    = '0;
    logic signed [63:0]  entry_dts    = '0;
    logic [31:0]         entry_seq    = '0;
    logic [15:0]         entry_handle = '0;
    logic                out_valid;
    logic                out_ready    = 1'b0;
    logic [1:0]          status;
    logic [31:0]         out_epoch;
    logic signed [63:0]  out_pts;
    logic signed [63:0]  out_dts;
    logic [31:0]         out_seq;
    logic [15:0]         out_handle;
    logic [HELD_W-1:0]   entries_held;

    // Model state and bookkeeping
    entry_t           sorted_entries[$];
    logic [LIM_W-1:0] limit_shadow = LIMIT_RESET;
    result_t          results_due[$];
    row_t             plan[$];
    int               fail_count    = 0;
    int               cycle_count   = 0;
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    logic             stall_wanted  = 1'b0;
    logic             stall_used    = 1'b0;
    int               stall_left    = 0;

    packet_reorder_priority_queue u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .entry_epoch  (entry_epoch),
        .entry_pts    (entry_pts),
        .entry_dts    (entry_dts),
        .entry_seq    (entry_seq),
        .entry_handle (entry_handle),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .out_epoch    (out_epoch),
        .out_pts      (out_pts),
        .out_dts      (out_dts),
        .out_seq      (out_seq),
        .out_handle   (out_handle),
        .entries_held (entries_held)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Strict ordering: epoch and seq unsigned, timestamps signed
    function automatic logic key_less(entry_t a, entry_t b);
        if (a.epoch != b.epoch)
            return a.epoch < b.epoch;
        if (a.pts != b.pts)
            return $signed(a.pts) < $signed(b.pts);
        if (a.dts != b.dts)
            return $signed(a.dts) < $signed(b.dts);
        return a.seq < b.seq;
    endfunction

    // Apply one operation to the sorted queue and return its result
    function automatic result_t sorted_queue_step(op_code_t op, entry_t e);
        result_t r;
        int      lim;
        int      pos;
        r   = '0;
        lim = (limit_shadow > DEPTH) ? DEPTH : int'(limit_shadow);
        if (op == OP_PUSH)
        begin
            if (sorted_entries.size() >= lim)
            begin
                r.status = STAT_FULL;
            end
            else
            begin
                // insert after every entry that is not greater
                pos = sorted_entries.size();
                while (pos > 0 && key_less(e, sorted_entries[pos-1]))
                    pos--;
                sorted_entries.insert(pos, e);
                r.status = STAT_OK;
            end
        end
        else if (sorted_entries.size() == 0)
        begin
            r.status = STAT_EMPTY;
        end
        else
        begin
            r.ent    = sorted_entries.pop_front();
            r.status = STAT_OK;
        end
        r.held = HELD_W'(sorted_entries.size());
        return r;
    endfunction

    // Timestamps biased toward ties, signs around zero and the extremes
    function automatic logic [63:0] pick_stamp();
        int v;
        v = int'($urandom_range(4)) - 2;
        case ($urandom_range(9))
            0:       return STAMP_MIN + 64'($urandom_range(1));
            1:       return STAMP_MAX - 64'($urandom_range(1));
            2, 3:    return {$urandom, $urandom};
            default: return {{32{v[31]}}, v};
        endcase
    endfunction

    function automatic entry_t pick_entry();
        entry_t e;
        if ($urandom_range(9) < 7)
            e.epoch = 32'($urandom_range(2));
        else if ($urandom_range(1) == 0)
            e.epoch = 32'hFFFF_FFFF;
        else
            e.epoch = $urandom;
        e.pts    = pick_stamp();
        e.dts    = pick_stamp();
        e.seq    = ($urandom_range(1) == 0) ? 32'($urandom_range(3)) : $urandom;
        e.handle = 16'($urandom);
        return e;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    task automatic plan_beat(op_code_t op, logic [31:0] ep, logic [63:0] pt,
                             logic [63:0] dt, logic [31:0] sq, logic [15:0] h);
        row_t r;
        r      = '0;
        r.kind = ROW_BEAT;
        r.op   = op;
        r.ent  = {ep, pt, dt, sq, h};
        plan.push_back(r);
    endtask

    // Pin the result of the last planned beat to a typed value
    task automatic plan_want(status_t st, int held);
        row_t r;
        r             = plan.pop_back();
        r.typed       = 1'b1;
        r.want        = '0;
        r.want.status = st;
        r.want.held   = HELD_W'(held);
        plan.push_back(r);
    endtask

    task automatic plan_limit(logic [LIM_W-1:0] value);
        row_t r;
        r       = '0;
        r.kind  = ROW_LIMIT;
        r.limit = value;
        plan.push_back(r);
    endtask

    // Offer one beat, hold it until accepted, then predict its result
    task automatic send_beat(op_code_t op, entry_t e, logic typed, result_t want);
        result_t got;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        entry_epoch  <= e.epoch;
        entry_pts    <= e.pts;
        entry_dts    <= e.dts;
        entry_seq    <= e.seq;
        entry_handle <= e.handle;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        got = sorted_queue_step(op, e);
        results_due.push_back(typed ? want : got);
    endtask

    // Write the limit once every result is out and the block is quiet
    task automatic write_limit(logic [LIM_W-1:0] value);
        in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        limit_shadow  = value;
    endtask

    // Check each result beat, then pick out_ready for the next cycle
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (results_due.size() == 0)
                begin
                    $error("unexpected result beat: status %0d, held %0d",
                           status, entries_held);
                    fail_count++;
                end
                else
                begin
                    want = results_due.pop_front();
                    check_field("status", 64'(want.status), 64'(status));
                    check_field("out_epoch", 64'(want.ent.epoch), 64'(out_epoch));
                    check_field("out_pts", want.ent.pts, out_pts);
                    check_field("out_dts", want.ent.dts, out_dts);
                    check_field("out_seq", 64'(want.ent.seq), 64'(out_seq));
                    check_field("out_handle", 64'(want.ent.handle), 64'(out_handle));
                    check_field("entries_held", 64'(want.held), 64'(entries_held));
                end
            end
            // hold off once for a long stretch so the input backs up
            if (stall_wanted && !stall_used)
            begin
                stall_used = 1'b1;
                stall_left = STALL_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        int      phase_limit[PHASES];
        int      phase_push[PHASES];
        int      phase_beats[PHASES];
        row_t    r;
        entry_t  e;
        result_t none;

        phase_limit = '{64, 1, 100, 17, 127};
        phase_push  = '{70, 50, 75, 55, 30};
        phase_beats = '{300, 150, 250, 150, 150};
        none        = '0;

        // Empty pop, key extremes, signed and unsigned ordering, ties
        plan_beat(OP_POP, 32'hFFFF_FFFF, STAMP_MAX, STAMP_MAX, '1, '1);
        plan_want(STAT_EMPTY, 0);
        plan_beat(OP_PUSH, 32'hFFFF_FFFF, STAMP_MAX, STAMP_MAX, '1, 16'hFFFF);
        plan_want(STAT_OK, 1);
        plan_beat(OP_PUSH, 32'h0, STAMP_MIN, STAMP_MIN, 32'h0, 16'h0000);
        plan_want(STAT_OK, 2);
        plan_beat(OP_PUSH, 32'd7, STAMP_NEG1, 64'd0, 32'd1, 16'h0101);
        plan_beat(OP_PUSH, 32'd7, 64'd0, 64'd0, 32'd1, 16'h0102);
        plan_beat(OP_PUSH, 32'd7, 64'd0, STAMP_NEG1, 32'd9, 16'h0103);
        plan_beat(OP_PUSH, 32'd7, 64'd0, 64'd0, 32'd0, 16'h0104);
        plan_beat(OP_PUSH, 32'd7, 64'd0, 64'd0, 32'd1, 16'h0105);
        plan_beat(OP_PUSH, 32'h8000_0000, 64'd0, 64'd0, 32'h8000_0000, 16'h0106);
        repeat (3) plan_beat(OP_POP, '1, STAMP_MIN, STAMP_MAX, '1, '1);
        // Limit equal to the fill, then below it
        plan_limit(7'd5);
        plan_beat(OP_PUSH, 32'd1, 64'd0, 64'd0, 32'd0, 16'hA5A5);
        plan_want(STAT_FULL, 5);
        plan_limit(7'd3);
        plan_beat(OP_PUSH, 32'd1, 64'd0, 64'd0, 32'd0, 16'h5A5A);
        plan_want(STAT_FULL, 5);
        repeat (2) plan_beat(OP_POP, '0, '0, '0, '0, '0);
        plan_beat(OP_PUSH, 32'd2, 64'd5, 64'd5, 32'd5, 16'h1234);
        plan_want(STAT_FULL, 3);
        plan_beat(OP_POP, '0, '0, '0, '0, '0);
        plan_beat(OP_PUSH, 32'd2, 64'd5, 64'd5, 32'd5, 16'h4321);
        // Zero limit refuses every push, pops still drain
        plan_limit(7'd0);
        plan_beat(OP_PUSH, 32'd0, STAMP_MIN, STAMP_MIN, 32'd0, 16'hFFFF);
        plan_want(STAT_FULL, 3);
        plan_beat(OP_POP, '0, '0, '0, '0, '0);
        // Limit above depth saturates
        plan_limit(7'd127);
        plan_beat(OP_PUSH, 32'hFFFF_FFFF, STAMP_MIN, STAMP_MAX, 32'd3, 16'h00FF);
        repeat (3) plan_beat(OP_POP, '0, '0, '0, '0, '0);
        plan_beat(OP_POP, '1, STAMP_NEG1, STAMP_NEG1, '1, '1);
        plan_want(STAT_EMPTY, 0);

        // Hold reset, then release on a clock edge
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 29;
        recv_idle_pct = 85;
        foreach (plan[i])
        begin
            r = plan[i];
            if (r.kind == ROW_LIMIT)
                write_limit(r.limit);
            else
                send_beat(r.op, r.ent, r.typed, r.want);
        end

        // Random phases, each under its own limit; the first two have their own idling pattern
        for (int p = 0; p < PHASES; p++)
        begin
            write_limit(LIM_W'(phase_limit[p]));
            if (p == 0)
            begin
                send_idle_pct = 29;
                recv_idle_pct = 85;
            end
            else if (p == 1)
            begin
                send_idle_pct = 85;
                recv_idle_pct = 29;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (p == 2)
                stall_wanted <= 1'b1;
            for (int n = 0; n < phase_beats[p]; n++)
            begin
                e = pick_entry();
                if ($urandom_range(99) < phase_push[p])
                    send_beat(OP_PUSH, e, 1'b0, none);
                else
                    send_beat(OP_POP, e, 1'b0, none);
            end
        end

        // Drain the last results, then report
        in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- packet_reorder_priority_queue.f -----
rtl/prq_pkg.sv
rtl/prq_dp.sv
rtl/prq_ctrl.sv
rtl/packet_reorder_priority_queue.sv
bench/tb.sv
